// ===== rtl/core/cstda_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cstda_pkg
// Shared types, codes and the saturating accumulate used by the sparse-times-
// dense accumulate core and its checker.
// ----------------------------------------------------------------------------
package cstda_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CPLX_W  = 64;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned ROW_W   = 6;
  localparam int unsigned COL_W   = 4;
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;

  localparam logic [LEN_W-1:0]   ROW_LEN_RST  = 5'd16;
  localparam logic [PADDR_W-1:0] ADDR_ROW_LEN = 2'd0;

  typedef enum logic [1:0] {
    REQ_LOAD_B = 2'd0,
    REQ_LOAD_C = 2'd1,
    REQ_TERM   = 2'd2,
    REQ_READ_C = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ovf;
  } sat_res_t;

  // acc + floor(prod / 2^16), clamped to the signed 32-bit range
  function automatic sat_res_t mac_sat(input logic signed [PROD_W-1:0] prod,
                                       input logic signed [DATA_W-1:0] acc);
    logic [48:0] sum;
    sat_res_t    res;
    sum = {prod[63], prod[63:16]} + {{17{acc[31]}}, acc};
    if (sum[48:31] != {18{sum[48]}}) begin
      res.ovf = 1'b1;
      res.val = sum[48] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      res.ovf = 1'b0;
      res.val = sum[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/coo_sparse_times_dense_accumulate_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// coo_sparse_times_dense_accumulate_core
// Sparse (coordinate form) times dense complex matrix, accumulated into a
// dense complex matrix C, Q16.16 fixed point with saturating sums.
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy is low. Element loads
// of B or C take effect at that edge and leave busy low, so one may follow
// every cycle. A read of C shows its transaction on out_re_o / out_im_o /
// saturated_o for exactly one cycle, marked by out_valid_o, in the cycle after
// the request; the receiver cannot hold it off and must sample it then. A new
// request may be issued in that same cycle. A term request (i, k, a) keeps
// busy high over n = min(row_len, MAX_COLS) columns: the C memory has one
// read and one write port, so the term walks its row one column per cycle
// through a read / multiply / add-and-saturate pipeline, and then waits for
// the last column to be written back. A term with n = 0 or with a row out of
// range does nothing and leaves busy low. B and C are not cleared by reset;
// reading an element that was never loaded gives an undefined value. The
// saturated flag is sticky from reset. row_len is written over the APB port
// at byte address 0, by the user only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module coo_sparse_times_dense_accumulate_core
  import cstda_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // request channel
  input  wire                      start,
  output logic                     busy,
  input  wire  [1:0]               req_type_i,
  input  wire  [ROW_W-1:0]         dest_row_i,
  input  wire  [ROW_W-1:0]         src_row_i,
  input  wire  [COL_W-1:0]         column_i,
  input  wire  signed [DATA_W-1:0] value_re_i,
  input  wire  signed [DATA_W-1:0] value_im_i,
  input  wire  signed [DATA_W-1:0] coef_i,
  // result channel
  output logic                     out_valid_o,
  output logic signed [DATA_W-1:0] out_re_o,
  output logic signed [DATA_W-1:0] out_im_o,
  output logic                     saturated_o,
  // configuration port
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire  [PADDR_W-1:0]       paddr,
  input  wire  [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  // storage, read data registered
  logic [CPLX_W-1:0] b_mem [DEPTH];
  logic [CPLX_W-1:0] c_mem [DEPTH];
  logic [CPLX_W-1:0] b_rd_q;
  logic [CPLX_W-1:0] c_rd_q;

  state_e state_q, state_d;

  logic [LEN_W-1:0]  row_len_q;
  logic              sat_q;

  // term context
  logic [ADDR_W-1:0]        dst_base_q;
  logic [ADDR_W-1:0]        src_base_q;
  logic [LEN_W-1:0]         len_q;
  logic [LEN_W-1:0]         cnt_q, cnt_d;
  logic signed [DATA_W-1:0] coef_q;

  // pipeline
  logic                     v1_q, v2_q;
  logic [ADDR_W-1:0]        waddr1_q, waddr2_q;
  logic signed [PROD_W-1:0] prod_re_q, prod_im_q;
  logic [CPLX_W-1:0]        cacc_q;

  // read result
  logic rd_pend_q;
  logic rd_ok_q;

  // request decode
  logic              accept;
  logic              dst_ok, src_ok, col_ok;
  logic [ADDR_W-1:0] dst_addr, src_addr, dst_base, src_base;
  logic [LEN_W-1:0]  len_n;
  logic              term_go;
  logic              issue;
  logic              last_col;

  // memory port controls
  logic              b_we, b_re;
  logic              c_we, c_re;
  logic [ADDR_W-1:0] c_waddr, c_raddr, c_iss_addr, b_iss_addr;
  logic [CPLX_W-1:0] c_wdata;

  sat_res_t          sat_re, sat_im;
  logic signed [DATA_W-1:0] b_re_s, b_im_s;

  logic cfg_wr;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign dst_ok = (32'(dest_row_i) < MAX_ROWS);
  assign src_ok = (32'(src_row_i) < MAX_ROWS);
  assign col_ok = (32'(column_i) < MAX_COLS);

  assign dst_base = ADDR_W'(32'(dest_row_i) * MAX_COLS);
  assign src_base = ADDR_W'(32'(src_row_i) * MAX_COLS);
  assign dst_addr = dst_base + ADDR_W'(column_i);
  assign src_addr = src_base + ADDR_W'(column_i);

  // columns per term, clipped to the row width
  always_comb begin
    if (32'(row_len_q) > MAX_COLS) begin
      len_n = LEN_W'(MAX_COLS);
    end else begin
      len_n = row_len_q;
    end
  end

  assign term_go  = accept && (req_type_i == REQ_TERM) && dst_ok && src_ok &&
                    (len_n != '0);
  assign last_col = (cnt_q == len_q - LEN_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (term_go) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (last_col) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        // last writeback happens at this edge when only stage two is left
        if (!v1_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    issue = 1'b0;
    cnt_d = '0;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
      end
      ST_ISSUE: begin
        issue = 1'b1;
        cnt_d = cnt_q + LEN_W'(1);
      end
      ST_DRAIN: begin
        cnt_d = cnt_q;
      end
      default: begin
        issue = 1'b0;
        cnt_d = '0;
      end
    endcase
  end

  assign c_iss_addr = dst_base_q + ADDR_W'(cnt_q);
  assign b_iss_addr = src_base_q + ADDR_W'(cnt_q);

  // stage two: truncate, accumulate, saturate
  assign sat_re = mac_sat(prod_re_q, $signed(cacc_q[31:0]));
  assign sat_im = mac_sat(prod_im_q, $signed(cacc_q[63:32]));

  // memory port muxing; loads only happen while idle, writebacks while busy
  assign b_we    = accept && (req_type_i == REQ_LOAD_B) && src_ok && col_ok;
  assign b_re    = issue;
  assign c_we    = v2_q || (accept && (req_type_i == REQ_LOAD_C) && dst_ok && col_ok);
  assign c_waddr = v2_q ? waddr2_q : dst_addr;
  assign c_wdata = v2_q ? {sat_im.val, sat_re.val} : {value_im_i, value_re_i};
  assign c_re    = issue || (accept && (req_type_i == REQ_READ_C));
  assign c_raddr = issue ? c_iss_addr : dst_addr;

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[src_addr] <= {value_im_i, value_re_i};
    end
    if (b_re) begin
      b_rd_q <= b_mem[b_iss_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      c_rd_q <= c_mem[c_raddr];
    end
  end

  // stage one: one multiplier per part
  assign b_re_s = $signed(b_rd_q[31:0]);
  assign b_im_s = $signed(b_rd_q[63:32]);

  always_ff @(posedge clk_i) begin
    if (term_go) begin
      dst_base_q <= dst_base;
      src_base_q <= src_base;
      len_q      <= len_n;
      coef_q     <= coef_i;
    end
    if (issue) begin
      waddr1_q <= c_iss_addr;
    end
    if (v1_q) begin
      prod_re_q <= coef_q * b_re_s;
      prod_im_q <= coef_q * b_im_s;
      cacc_q    <= c_rd_q;
      waddr2_q  <= waddr1_q;
    end
    if (accept) begin
      rd_ok_q <= dst_ok && col_ok;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      rd_pend_q <= 1'b0;
      sat_q     <= 1'b0;
      row_len_q <= ROW_LEN_RST;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      v1_q      <= issue;
      v2_q      <= v1_q;
      rd_pend_q <= accept && (req_type_i == REQ_READ_C);
      if (v2_q && (sat_re.ovf || sat_im.ovf)) begin
        sat_q <= 1'b1;
      end
      if (cfg_wr) begin
        row_len_q <= pwdata[LEN_W-1:0];
      end
    end
  end

  // read transaction, out-of-range element reads as zero
  assign out_valid_o = rd_pend_q;
  assign out_re_o    = rd_ok_q ? $signed(c_rd_q[31:0])  : '0;
  assign out_im_o    = rd_ok_q ? $signed(c_rd_q[63:32]) : '0;
  assign saturated_o = sat_q;

  // apb register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_ROW_LEN);
  assign prdata = (paddr == ADDR_ROW_LEN) ? PDATA_W'(row_len_q) : '0;

endmodule
`default_nettype wire

// ===== rtl/core/cstda_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cstda_checker
// Port-level checks of request and result timing for the accumulate core.
// ----------------------------------------------------------------------------
module cstda_checker
  import cstda_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       start,
  input wire       busy,
  input wire [1:0] req_type_i,
  input wire       out_valid_o,
  input wire       saturated_o
);

  // a result only follows an accepted read
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start && !busy && (req_type_i == REQ_READ_C)))
    else $error("result without a read request");

  // every accepted read gives a result in the next cycle
  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_type_i == REQ_READ_C)) |=> out_valid_o)
    else $error("read request lost");

  // loads and reads never stall the request side
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_type_i != REQ_TERM)) |=> !busy)
    else $error("busy after a load or read");

  // saturation flag is sticky
  a_sat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saturated_o |=> saturated_o)
    else $error("saturated flag cleared");

endmodule

bind coo_sparse_times_dense_accumulate_core cstda_checker u_cstda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_type_i  (req_type_i),
  .out_valid_o (out_valid_o),
  .saturated_o (saturated_o)
);
`default_nettype wire
